### src/spm_pkg.sv
`timescale 1ns / 1ps

package spm_pkg;

   // fixed field widths of the stream payload
   localparam int SAMPLE_W    = 24;
   localparam int COEF_W      = 18;
   localparam int FRAC_W      = 16;
   localparam int CH_FIELD_W  = 6;
   localparam int TAP_FIELD_W = 5;
   localparam int NCH_W       = 7;
   localparam int HW_W        = 4;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 8;

   localparam int DEFAULT_MAX_CHANNELS = 64;
   localparam int DEFAULT_MAX_WINDOW   = 31;

   localparam logic [NCH_W-1:0] NUM_CHANNELS_RESET = 7'd64;
   localparam logic [HW_W-1:0]  HALF_WINDOW_RESET  = 4'd15;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_CHANNELS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_WINDOW  = 1'b1;

   localparam logic ACT_LOAD_COEF = 1'b0;
   localparam logic ACT_SAMPLE    = 1'b1;

   typedef struct packed {
      logic                  frame_we;
      logic                  coef_we;
      logic                  rd_en;
      logic                  first_tap;
      logic                  last_tap;
      logic                  own_tap;
      logic                  load_result;
      logic                  out_last;
      logic [CH_FIELD_W-1:0] out_channel;
   } cmd_type;

   typedef struct packed {
      logic sum_ready;
      logic out_free;
   } sts_type;

endpackage

### src/spm_ram.sv
`timescale 1ns / 1ps

module spm_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/spm_ctrl.sv
`timescale 1ns / 1ps

module spm_ctrl #(
   parameter int  MAX_CHANNELS = 64,
   parameter int  MAX_WINDOW   = 31,
   localparam int IDX_W        = $clog2(MAX_CHANNELS),
   localparam int COEF_AW      = (MAX_CHANNELS * MAX_WINDOW > 1) ?
                                 $clog2(MAX_CHANNELS * MAX_WINDOW) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [spm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [spm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic                                 action,
   input  logic [spm_pkg::CH_FIELD_W-1:0]       coef_channel,
   input  logic [spm_pkg::TAP_FIELD_W-1:0]      coef_tap,
   output spm_pkg::cmd_type                     cmd,
   output logic [IDX_W-1:0]                     frame_waddr,
   output logic [IDX_W-1:0]                     frame_raddr,
   output logic [COEF_AW-1:0]                   coef_waddr,
   output logic [COEF_AW-1:0]                   coef_raddr,
   input  spm_pkg::sts_type                     sts
);

   import spm_pkg::*;

   localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
   localparam int TAP_W  = $clog2(MAX_WINDOW + 1);
   localparam int NB_W   = IDX_W + 6;
   localparam int HW_LIM = (MAX_WINDOW - 1) / 2;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_WAIT  = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [NCH_W-1:0]         num_channels_ff, num_channels_in;
   logic [HW_W-1:0]          half_window_ff, half_window_in;
   logic [IDX_W-1:0]         fill_count_ff, fill_count_in;
   logic [IDX_W-1:0]         chan_ff, chan_in;
   logic [TAP_W-1:0]         tap_ff, tap_in;
   logic signed [NB_W-1:0]   nb_ff, nb_in;
   logic [COEF_AW-1:0]       base_ff, base_in;

   logic [CNT_W-1:0]         n_eff;
   logic [HW_W-1:0]          hw_eff;
   logic [TAP_W-1:0]         last_tap_idx;
   logic                     accept;
   logic                     frame_done;
   logic                     chan_is_last;
   logic                     coef_in_range;

   always_comb begin
      if (num_channels_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(num_channels_ff) > MAX_CHANNELS) begin
         n_eff = CNT_W'(MAX_CHANNELS);
      end else begin
         n_eff = CNT_W'(num_channels_ff);
      end
      hw_eff = (32'(half_window_ff) > HW_LIM) ? HW_W'(HW_LIM) : half_window_ff;
   end

   assign last_tap_idx  = TAP_W'({hw_eff, 1'b0});
   assign accept        = req_tvalid && req_tready;
   assign frame_done    = (CNT_W'(fill_count_ff) + CNT_W'(1)) >= n_eff;
   assign chan_is_last  = (CNT_W'(chan_ff) + CNT_W'(1)) == n_eff;
   assign coef_in_range = (32'(coef_channel) < MAX_CHANNELS) &&
                          (32'(coef_tap) < MAX_WINDOW);

   assign req_tready  = (state_ff == ST_IDLE);
   assign frame_waddr = fill_count_ff;
   assign coef_waddr  = COEF_AW'(32'(coef_channel) * MAX_WINDOW + 32'(coef_tap));
   assign coef_raddr  = base_ff + COEF_AW'(tap_ff);

   // edge channels repeat outside the frame
   always_comb begin
      if (nb_ff < 0) begin
         frame_raddr = '0;
      end else if (nb_ff >= $signed(NB_W'(n_eff))) begin
         frame_raddr = IDX_W'(n_eff - CNT_W'(1));
      end else begin
         frame_raddr = IDX_W'(nb_ff);
      end
   end

   always_comb begin
      num_channels_in = num_channels_ff;
      half_window_in  = half_window_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_CHANNELS: num_channels_in = csr_wdata;
            CSR_HALF_WINDOW:  half_window_in  = csr_wdata[HW_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      chan_in       = chan_ff;
      tap_in        = tap_ff;
      nb_in         = nb_ff;
      base_in       = base_ff;

      cmd             = '0;
      cmd.out_channel = CH_FIELD_W'(chan_ff);
      cmd.out_last    = chan_is_last;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (action == ACT_LOAD_COEF) begin
                  cmd.coef_we = coef_in_range;
               end else begin
                  cmd.frame_we = 1'b1;
                  if (frame_done) begin
                     fill_count_in = '0;
                     chan_in       = '0;
                     tap_in        = '0;
                     base_in       = '0;
                     nb_in         = -$signed(NB_W'(hw_eff));
                     state_in      = ST_ISSUE;
                  end else begin
                     fill_count_in = fill_count_ff + IDX_W'(1);
                  end
               end
            end
         end
         ST_ISSUE: begin
            cmd.rd_en     = 1'b1;
            cmd.first_tap = (tap_ff == '0);
            cmd.last_tap  = (tap_ff == last_tap_idx);
            cmd.own_tap   = (tap_ff == TAP_W'(hw_eff));
            tap_in        = tap_ff + TAP_W'(1);
            nb_in         = nb_ff + NB_W'(1);
            if (tap_ff == last_tap_idx) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (sts.sum_ready && sts.out_free) begin
               cmd.load_result = 1'b1;
               if (chan_is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  chan_in  = chan_ff + IDX_W'(1);
                  tap_in   = '0;
                  base_in  = base_ff + COEF_AW'(MAX_WINDOW);
                  nb_in    = $signed(NB_W'(chan_ff)) + NB_W'(1) - $signed(NB_W'(hw_eff));
                  state_in = ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         num_channels_ff <= NUM_CHANNELS_RESET;
         half_window_ff  <= HALF_WINDOW_RESET;
         fill_count_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         num_channels_ff <= num_channels_in;
         half_window_ff  <= half_window_in;
         fill_count_ff   <= fill_count_in;
      end
      chan_ff <= chan_in;
      tap_ff  <= tap_in;
      nb_ff   <= nb_in;
      base_ff <= base_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> sts.sum_ready && sts.out_free)
      else $error("result loaded without a finished sum or a free output");

   assert property (@(posedge clock) disable iff (reset)
      32'(fill_count_ff) < MAX_CHANNELS)
      else $error("fill count beyond frame store");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) && (state_in == ST_WAIT) |-> cmd.last_tap)
      else $error("window left before its last tap");

   assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !req_tready)
      else $error("taps issued while input is open");

endmodule

### src/spm_datapath.sv
`timescale 1ns / 1ps

module spm_datapath #(
   parameter int  MAX_CHANNELS = 64,
   parameter int  MAX_WINDOW   = 31,
   localparam int IDX_W        = $clog2(MAX_CHANNELS),
   localparam int COEF_AW      = (MAX_CHANNELS * MAX_WINDOW > 1) ?
                                 $clog2(MAX_CHANNELS * MAX_WINDOW) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  spm_pkg::cmd_type                  cmd,
   input  logic [IDX_W-1:0]                  frame_waddr,
   input  logic [IDX_W-1:0]                  frame_raddr,
   input  logic [COEF_AW-1:0]                coef_waddr,
   input  logic [COEF_AW-1:0]                coef_raddr,
   input  logic [spm_pkg::SAMPLE_W-1:0]      sample,
   input  logic [spm_pkg::COEF_W-1:0]        coef_value,
   output spm_pkg::sts_type                  sts,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              above_threshold,
   output logic [spm_pkg::CH_FIELD_W-1:0]    channel,
   output logic                              last
);

   import spm_pkg::*;

   localparam int PROD_W = SAMPLE_W + COEF_W + 1;
   localparam int ACC_W  = PROD_W + $clog2(MAX_WINDOW + 1);

   logic [SAMPLE_W-1:0]      frame_rdata;
   logic [COEF_W-1:0]        coef_rdata;

   logic                     s1_valid_ff, s1_first_ff, s1_last_ff, s1_own_ff;
   logic                     s2_valid_ff, s2_first_ff, s2_last_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [SAMPLE_W-1:0]      own_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  own_scaled;
   logic                     sum_ready_ff, sum_ready_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     above_ff;
   logic [CH_FIELD_W-1:0]    channel_ff;
   logic                     last_ff;

   spm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_CHANNELS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (cmd.frame_we),
      .wr_addr (frame_waddr),
      .wr_data (sample),
      .rd_en   (cmd.rd_en),
      .rd_addr (frame_raddr),
      .rd_data (frame_rdata)
   );

   spm_ram #(
      .WIDTH (COEF_W),
      .DEPTH (MAX_CHANNELS * MAX_WINDOW)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (cmd.coef_we),
      .wr_addr (coef_waddr),
      .wr_data (coef_value),
      .rd_en   (cmd.rd_en),
      .rd_addr (coef_raddr),
      .rd_data (coef_rdata)
   );

   assign prod_in = $signed(frame_rdata) * $signed({1'b0, coef_rdata});

   assign acc_in = s2_first_ff ? ACC_W'(prod_ff)
                               : acc_ff + ACC_W'(prod_ff);

   // own sample in the same Q format as the sum
   assign own_scaled = $signed({{(ACC_W - SAMPLE_W - FRAC_W){own_ff[SAMPLE_W-1]}},
                                own_ff, {FRAC_W{1'b0}}});

   assign sts.sum_ready = sum_ready_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sum_ready_in = sum_ready_ff;
      if (cmd.load_result) begin
         sum_ready_in = 1'b0;
      end else if (s2_valid_ff && s2_last_ff) begin
         sum_ready_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         sum_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.rd_en;
         s2_valid_ff  <= s1_valid_ff;
         sum_ready_ff <= sum_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end

      s1_first_ff <= cmd.first_tap;
      s1_last_ff  <= cmd.last_tap;
      s1_own_ff   <= cmd.own_tap;

      if (s1_valid_ff) begin
         prod_ff     <= prod_in;
         s2_first_ff <= s1_first_ff;
         s2_last_ff  <= s1_last_ff;
         if (s1_own_ff) begin
            own_ff <= frame_rdata;
         end
      end

      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end

      if (cmd.load_result) begin
         above_ff   <= own_scaled > acc_ff;
         channel_ff <= cmd.out_channel;
         last_ff    <= cmd.out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign above_threshold = above_ff;
   assign channel         = channel_ff;
   assign last            = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_last_ff |=> sum_ready_ff)
      else $error("finished window sum not flagged");

   assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !sum_ready_ff)
      else $error("taps issued over an unread sum");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> !s1_valid_ff && !s2_valid_ff)
      else $error("result taken while taps still in flight");

endmodule

### src/spectral_masking_threshold.sv
`timescale 1ns / 1ps

// channel | direction | tdata / data (lsb first)                        | tuser  | tlast
// req     | in        | coef_channel, coef_tap, coef_value, sample       | action | -
// rsp     | out       | above_threshold, channel                         | -      | last
// csr     | in        | csr_index selects num_channels or half_window    | -      | -
//
// a coefficient load or a sample that leaves the frame open keeps the input ready
// the sample that closes a frame holds the input until the results of all n channels are loaded,
// while the one shared multiply-accumulate walks each channel window, 2 * hw + 1 taps wide, tap by tap
// n and hw are the effective channel count and half window
// reset is synchronous; no clearing pass, the stores are valid once written
// a stalled result holds its register; the window walk waits for it to drain

module spectral_masking_threshold #(
   parameter int MAX_CHANNELS = spm_pkg::DEFAULT_MAX_CHANNELS,
   parameter int MAX_WINDOW   = spm_pkg::DEFAULT_MAX_WINDOW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [spm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [spm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // coef_channel[5:0], coef_tap[10:6], coef_value[28:11], sample[52:29], zero fill
   input  logic [spm_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // action
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // above_threshold[0], channel[6:1], zero fill
   output logic [spm_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);

   import spm_pkg::*;

   localparam int IDX_W   = $clog2(MAX_CHANNELS);
   localparam int COEF_AW = (MAX_CHANNELS * MAX_WINDOW > 1) ?
                            $clog2(MAX_CHANNELS * MAX_WINDOW) : 1;

   cmd_type                 cmd;
   sts_type                 sts;
   logic [IDX_W-1:0]        frame_waddr, frame_raddr;
   logic [COEF_AW-1:0]      coef_waddr, coef_raddr;
   logic                    above_threshold;
   logic [CH_FIELD_W-1:0]   channel;

   spm_ctrl #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_WINDOW   (MAX_WINDOW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .action       (req_tuser),
      .coef_channel (req_tdata[5:0]),
      .coef_tap     (req_tdata[10:6]),
      .cmd          (cmd),
      .frame_waddr  (frame_waddr),
      .frame_raddr  (frame_raddr),
      .coef_waddr   (coef_waddr),
      .coef_raddr   (coef_raddr),
      .sts          (sts)
   );

   spm_datapath #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_WINDOW   (MAX_WINDOW)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .frame_waddr     (frame_waddr),
      .frame_raddr     (frame_raddr),
      .coef_waddr      (coef_waddr),
      .coef_raddr      (coef_raddr),
      .sample          (req_tdata[52:29]),
      .coef_value      (req_tdata[28:11]),
      .sts             (sts),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .above_threshold (above_threshold),
      .channel         (channel),
      .last            (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, channel, above_threshold};

endmodule

### test/spectral_masking_threshold_tb.sv
`timescale 1ns / 1ps

module spectral_masking_threshold_tb;
   import spm_pkg::*;

   localparam int NCH           = DEFAULT_MAX_CHANNELS;
   localparam int NWIN          = DEFAULT_MAX_WINDOW;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 200;

   typedef struct packed {
      logic                  above;
      logic [CH_FIELD_W-1:0] channel;
      logic                  last;
   } decision_type;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata;
   logic                     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     rsp_tlast;

   spectral_masking_threshold dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // shadow copy of the block state
   logic [COEF_W-1:0]          shadow_coef [NCH*NWIN];
   bit                         shadow_coef_set [NCH*NWIN];
   logic signed [SAMPLE_W-1:0] shadow_frame [NCH];
   int                         shadow_fill;
   logic [NCH_W-1:0]           shadow_nch;
   logic [HW_W-1:0]            shadow_hw;

   decision_type decision_q[$];

   int errors;
   int cycles;
   int samples_sent;
   int loads_sent;
   int frames_done;
   int decisions_checked;
   int above_seen;
   int burst_left;

   bit             hold_trigger;
   int             hold_left;
   int             mode_left;
   rx_pattern_type rx_pattern;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d decisions outstanding", cycles,
                  decision_q.size());
         $display("spectral_masking_threshold regression: fail");
         $finish;
      end
   end

   function automatic int eff_nch();
      if (shadow_nch == 0) return 1;
      if (int'(shadow_nch) > NCH) return NCH;
      return int'(shadow_nch);
   endfunction

   function automatic int eff_hw();
      int lim;
      lim = (NWIN - 1) / 2;
      return (int'(shadow_hw) > lim) ? lim : int'(shadow_hw);
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
         1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
         2: return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   task automatic flag_error(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
   endtask

   // update the shadow state and queue the per-channel decisions a closed frame yields
   task automatic predict_decisions(input logic act, input logic [CH_FIELD_W-1:0] ch,
                                    input logic [TAP_FIELD_W-1:0] tap,
                                    input logic [COEF_W-1:0] val,
                                    input logic [SAMPLE_W-1:0] smp);
      int           n;
      int           hw;
      int           k;
      int           m;
      int           idx;
      longint       sum;
      longint       own;
      decision_type d;
      if (act == ACT_LOAD_COEF) begin
         loads_sent++;
         if (int'(ch) < NCH && int'(tap) < NWIN) begin
            shadow_coef[int'(ch)*NWIN + int'(tap)] = val;
            shadow_coef_set[int'(ch)*NWIN + int'(tap)] = 1'b1;
         end
         return;
      end
      samples_sent++;
      n = eff_nch();
      if (shadow_fill >= NCH) shadow_fill = 0;
      shadow_frame[shadow_fill] = smp;
      shadow_fill++;
      if (shadow_fill < n) return;
      shadow_fill = 0;
      frames_done++;
      hw = eff_hw();
      for (k = 0; k < n; k++) begin
         sum = 0;
         for (m = -hw; m <= hw; m++) begin
            idx = k + m;
            if (idx < 0) idx = 0;
            if (idx >= n) idx = n - 1;
            sum += longint'(shadow_frame[idx]) * longint'(shadow_coef[k*NWIN + m + hw]);
         end
         own       = longint'(shadow_frame[k]);
         d.above   = (own * 65536 > sum);
         d.channel = CH_FIELD_W'(k);
         d.last    = (k == n - 1);
         decision_q.push_back(d);
      end
   endtask

   task automatic send_item(input logic act, input logic [CH_FIELD_W-1:0] ch,
                            input logic [TAP_FIELD_W-1:0] tap, input logic [COEF_W-1:0] val,
                            input logic [SAMPLE_W-1:0] smp);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= REQ_TDATA_W'({smp, val, tap, ch});
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_decisions(act, ch, tap, val, smp);
   endtask

   // unused fields carry random bits, the block must ignore them
   task automatic send_load(input int ch, input int tap, input int val);
      send_item(ACT_LOAD_COEF, CH_FIELD_W'(ch), TAP_FIELD_W'(tap), COEF_W'(val),
                SAMPLE_W'($urandom()));
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
      send_item(ACT_SAMPLE, CH_FIELD_W'($urandom()), TAP_FIELD_W'($urandom()),
                COEF_W'($urandom()), smp);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (decision_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_NUM_CHANNELS) shadow_nch = data[NCH_W-1:0];
      else shadow_hw = data[HW_W-1:0];
   endtask

   // every coefficient the current window can read must hold a value
   task automatic load_missing_coefs();
      int c;
      int t;
      for (c = 0; c < eff_nch(); c++)
         for (t = 0; t <= 2 * eff_hw(); t++)
            if (!shadow_coef_set[c*NWIN + t])
               send_load(c, t, $urandom_range(0, 2**COEF_W - 1));
   endtask

   task automatic set_config(input int nch, input int hw);
      logic [CSR_DATA_W-1:0] hw_word;
      wait_idle();
      write_reg(CSR_NUM_CHANNELS, CSR_DATA_W'(nch));
      hw_word = CSR_DATA_W'($urandom());
      hw_word[HW_W-1:0] = HW_W'(hw);
      write_reg(CSR_HALF_WINDOW, hw_word);
      load_missing_coefs();
   endtask

   // receiver: changing stall patterns, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_trigger) begin
         hold_trigger = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
         rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_pattern)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= (cycles % 7 < 4);
         endcase
      end
   end

   always @(posedge clock) begin
      decision_type want;
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (decision_q.size() == 0) begin
            flag_error($sformatf("unexpected transaction channel %0d",
                                 rsp_tdata[CH_FIELD_W:1]));
         end else begin
            want = decision_q.pop_front();
            decisions_checked++;
            if (rsp_tdata[0] === 1'b1) above_seen++;
            if (rsp_tdata[0] !== want.above)
               flag_error($sformatf("channel %0d above_threshold %b, expected %b",
                                    want.channel, rsp_tdata[0], want.above));
            if (rsp_tdata[CH_FIELD_W:1] !== want.channel)
               flag_error($sformatf("channel %0d, expected %0d",
                                    rsp_tdata[CH_FIELD_W:1], want.channel));
            if (rsp_tlast !== want.last)
               flag_error($sformatf("channel %0d last %b, expected %b",
                                    want.channel, rsp_tlast, want.last));
         end
      end
   end

   // widest window from the reset half window, on a zero count that acts as one channel
   task automatic test_default_window();
      write_reg(CSR_NUM_CHANNELS, '0);
      load_missing_coefs();
      send_sample(24'h800000);
      send_sample(24'h7FFFFF);
      send_sample(random_sample());
   endtask

   // one channel, every tap sees the own sample: zero weights, unity centre, maximum weights
   task automatic test_sample_extremes();
      int t;
      set_config(1, 1);
      for (t = 0; t < 3; t++) send_load(0, t, 0);
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      send_sample(24'h000000);
      send_load(0, 1, 1 << FRAC_W);
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      send_sample(24'hFFFFFF);
      for (t = 0; t < 3; t++) send_load(0, t, 2**COEF_W - 1);
      send_sample(24'h800000);
      send_sample(24'h7FFFFF);
      send_sample(24'h000001);
   endtask

   // a count above the maximum behaves as the maximum
   task automatic test_channel_count_limits();
      set_config(127, 0);
      repeat (NCH) send_sample(random_sample());
   endtask

   // tap 31 is past the window store and must not land on a neighbor entry
   task automatic test_out_of_range_loads();
      int c;
      set_config(3, 1);
      for (c = 0; c < 3; c++) send_load(c, NWIN, $urandom_range(0, 2**COEF_W - 1));
      send_load(NCH - 1, NWIN, 2**COEF_W - 1);
      repeat (3) send_sample(random_sample());
   endtask

   // lowering the count while a frame is open closes it on the next sample
   task automatic test_shrink_mid_frame();
      int i;
      set_config(4, 1);
      while (shadow_fill != 0) send_sample(random_sample());
      for (i = 0; i < 3; i++) begin
         send_sample(random_sample());
         send_load($urandom_range(0, 3), $urandom_range(0, 2), $urandom_range(0, 2**COEF_W - 1));
      end
      set_config(2, 1);
      send_sample(random_sample());
      repeat (2) send_sample(random_sample());
   endtask

   task automatic test_result_backpressure();
      set_config(2, 1);
      hold_trigger = 1'b1;
      repeat (8) send_sample(random_sample());
      wait_idle();
   endtask

   initial begin
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      rsp_tready  = 1'b0;
      shadow_fill = 0;
      shadow_nch  = NUM_CHANNELS_RESET;
      shadow_hw   = HALF_WINDOW_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_default_window();
      test_sample_extremes();
      test_channel_count_limits();
      test_out_of_range_loads();
      test_shrink_mid_frame();
      test_result_backpressure();

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d samples in %0d frames and %0d coefficient loads", samples_sent,
               frames_done, loads_sent);
      $display("checked %0d channel decisions (%0d above threshold), %0d errors",
               decisions_checked, above_seen, errors);
      if (errors == 0) begin
         $display("spectral_masking_threshold regression: pass");
      end else begin
         $display("spectral_masking_threshold regression: fail");
      end
      $finish;
   end

endmodule
